>>> rtl/ttb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared constants, codes and the command record passed from the
// classifier to the bin engine of the triangle tile binner.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int TILE_SIZE    = 16;
  localparam int TILE_SHIFT   = $clog2(TILE_SIZE);
  localparam int MAX_TILES_X  = 32;
  localparam int MAX_TILES_Y  = 32;
  localparam int TX_W         = $clog2(MAX_TILES_X);
  localparam int TY_W         = $clog2(MAX_TILES_Y);
  localparam int TILE_W       = TX_W + TY_W;
  localparam int NUM_TILES    = MAX_TILES_X * MAX_TILES_Y;
  localparam int TCX_W        = $clog2(MAX_TILES_X + 1);
  localparam int TCY_W        = $clog2(MAX_TILES_Y + 1);
  localparam int BIN_CAPACITY = 64;
  localparam int POS_W        = $clog2(BIN_CAPACITY);
  localparam int CNT_W        = $clog2(BIN_CAPACITY + 1);
  localparam int TRI_W        = 16;
  localparam int STORE_AW     = TILE_W + POS_W;
  localparam int COV_W        = 11;
  localparam int COORD_W      = 16;
  localparam int MT_W         = COORD_W - TILE_SHIFT;
  localparam int DIM_W        = 10;
  localparam int ACT_W        = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int QUEUE_DEPTH  = 4;
  localparam int Q_PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(512);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [ACT_W-1:0] {
    ACT_BIN   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    OP_BIN       = 3'd0,
    OP_CULL      = 3'd1,
    OP_READ      = 3'd2,
    OP_MISS      = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_NOP       = 3'd5,
    OP_BIN_EMPTY = 3'd6
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [TX_W-1:0]  tx0;
    logic [TX_W-1:0]  tx1;
    logic [TY_W-1:0]  ty0;
    logic [TY_W-1:0]  ty1;
    logic [TILE_W-1:0] rd_tile;
    logic [POS_W-1:0] rd_pos;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/triangle_tile_binner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_tile_binner
// Sorts triangles into 16x16 pixel screen tiles and serves bin reads.
//
// Input channel (in_*): one transaction per action (bin, read, clear).
// Result channel (out_*): exactly one result transaction per input, in order.
// Configuration (cfg_*): image width / height, written while the block idles.
// A classifier registers each transaction and places a command in a four-deep
// queue; the bin engine behind it appends to one tile per cycle through the
// single write port of the bin count and bin entry memories.
// The engine pops the next command only after it has loaded the result of the
// last one; a binned triangle occupies it for the tiles in its clamped box, and
// a clear sweeps all 1024 bin counts. After reset the block sweeps the 1024 bin
// counts to zero, holding in_stall high meanwhile. A stalled result waits in the
// output register; the queue keeps taking input until it fills.
// ----------------------------------------------------------------------------
module triangle_tile_binner (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ttb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ttb_pkg::DIM_W-1:0]       cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ttb_pkg::ACT_W-1:0]       in_action,
  input  wire logic signed [ttb_pkg::COORD_W-1:0] in_x0,
  input  wire logic signed [ttb_pkg::COORD_W-1:0] in_y0,
  input  wire logic signed [ttb_pkg::COORD_W-1:0] in_x1,
  input  wire logic signed [ttb_pkg::COORD_W-1:0] in_y1,
  input  wire logic signed [ttb_pkg::COORD_W-1:0] in_x2,
  input  wire logic signed [ttb_pkg::COORD_W-1:0] in_y2,
  input  wire logic [ttb_pkg::TX_W-1:0]        in_tile_x,
  input  wire logic [ttb_pkg::TY_W-1:0]        in_tile_y,
  input  wire logic [ttb_pkg::POS_W-1:0]       in_entry_index,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [ttb_pkg::TRI_W-1:0]            out_triangle_id,
  output logic [ttb_pkg::COV_W-1:0]            out_tiles_covered,
  output logic                                 out_culled,
  output logic                                 out_bin_overflow,
  output logic [ttb_pkg::CNT_W-1:0]            out_bin_count,
  output logic [ttb_pkg::TRI_W-1:0]            out_entry_triangle
);
  import ttb_pkg::*;

  logic init_busy;
  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_data, q_head;

  ttb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_x0          (in_x0),
    .in_y0          (in_y0),
    .in_x1          (in_x1),
    .in_y1          (in_y1),
    .in_x2          (in_x2),
    .in_y2          (in_y2),
    .in_tile_x      (in_tile_x),
    .in_tile_y      (in_tile_y),
    .in_entry_index (in_entry_index),
    .init_busy      (init_busy),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_data)
  );

  ttb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  ttb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .init_busy          (init_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_triangle_id    (out_triangle_id),
    .out_tiles_covered  (out_tiles_covered),
    .out_culled         (out_culled),
    .out_bin_overflow   (out_bin_overflow),
    .out_bin_count      (out_bin_count),
    .out_entry_triangle (out_entry_triangle)
  );

endmodule
`default_nettype wire

>>> rtl/ttb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_front
// Input stage: holds the configuration, takes input transactions and
// classifies each into a command (bounding box, cull, tile ranges, read hit).
// ----------------------------------------------------------------------------
module ttb_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ttb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ttb_pkg::DIM_W-1:0]       cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ttb_pkg::ACT_W-1:0]       in_action,
  input  wire logic signed [ttb_pkg::COORD_W-1:0] in_x0,
  input  wire logic signed [ttb_pkg::COORD_W-1:0] in_y0,
  input  wire logic signed [ttb_pkg::COORD_W-1:0] in_x1,
  input  wire logic signed [ttb_pkg::COORD_W-1:0] in_y1,
  input  wire logic signed [ttb_pkg::COORD_W-1:0] in_x2,
  input  wire logic signed [ttb_pkg::COORD_W-1:0] in_y2,
  input  wire logic [ttb_pkg::TX_W-1:0]        in_tile_x,
  input  wire logic [ttb_pkg::TY_W-1:0]        in_tile_y,
  input  wire logic [ttb_pkg::POS_W-1:0]       in_entry_index,
  input  wire logic                            init_busy,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output ttb_pkg::cmd_t                        q_data
);
  import ttb_pkg::*;

  logic [DIM_W-1:0]          img_w_r, img_w_nxt;
  logic [DIM_W-1:0]          img_h_r, img_h_nxt;
  logic                      fr_valid_r, fr_valid_nxt;
  logic [ACT_W-1:0]          fr_action_r;
  logic signed [COORD_W-1:0] fr_x0_r, fr_y0_r, fr_x1_r, fr_y1_r, fr_x2_r, fr_y2_r;
  logic [TX_W-1:0]           fr_tile_x_r;
  logic [TY_W-1:0]           fr_tile_y_r;
  logic [POS_W-1:0]          fr_pos_r;
  logic                      accept;

  logic [DIM_W:0]            wsum, hsum;
  logic [DIM_W:0]            tcx_raw, tcy_raw;
  logic [TCX_W-1:0]          tcx, tcx_m1;
  logic [TCY_W-1:0]          tcy, tcy_m1;
  logic signed [COORD_W:0]   spanx, spany;
  logic signed [COORD_W-1:0] minx, maxx, miny, maxy, mx01, xx01, my01, xy01;
  logic signed [COORD_W:0]   minx_e, miny_e;
  logic [MT_W-1:0]           mtx, mty;
  logic                      culled, miss, grid_empty;

  assign accept   = in_valid && !in_stall;
  assign in_stall = init_busy || (fr_valid_r && q_full);
  assign q_push   = fr_valid_r && !q_full;

  always_comb begin
    img_w_nxt = img_w_r;
    img_h_nxt = img_h_r;
    if (cfg_we) begin
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        img_w_nxt = cfg_data;
      end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
        img_h_nxt = cfg_data;
      end
    end
    fr_valid_nxt = accept ? 1'b1 : (q_push ? 1'b0 : fr_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r    <= DIM_RESET;
      img_h_r    <= DIM_RESET;
      fr_valid_r <= 1'b0;
    end else begin
      img_w_r    <= img_w_nxt;
      img_h_r    <= img_h_nxt;
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_action_r <= in_action;
      fr_x0_r     <= in_x0;
      fr_y0_r     <= in_y0;
      fr_x1_r     <= in_x1;
      fr_y1_r     <= in_y1;
      fr_x2_r     <= in_x2;
      fr_y2_r     <= in_y2;
      fr_tile_x_r <= in_tile_x;
      fr_tile_y_r <= in_tile_y;
      fr_pos_r    <= in_entry_index;
    end
  end

  // grid size in tiles, rounded up and capped
  always_comb begin
    wsum    = {1'b0, img_w_r} + (DIM_W+1)'(TILE_SIZE - 1);
    hsum    = {1'b0, img_h_r} + (DIM_W+1)'(TILE_SIZE - 1);
    tcx_raw = wsum >> TILE_SHIFT;
    tcy_raw = hsum >> TILE_SHIFT;
    tcx     = (tcx_raw > (DIM_W+1)'(MAX_TILES_X)) ? TCX_W'(MAX_TILES_X) : TCX_W'(tcx_raw);
    tcy     = (tcy_raw > (DIM_W+1)'(MAX_TILES_Y)) ? TCY_W'(MAX_TILES_Y) : TCY_W'(tcy_raw);
    tcx_m1  = tcx - TCX_W'(1);
    tcy_m1  = tcy - TCY_W'(1);
    spanx   = (COORD_W+1)'(tcx) << TILE_SHIFT;
    spany   = (COORD_W+1)'(tcy) << TILE_SHIFT;
  end

  // bounding box and classification
  always_comb begin
    mx01   = (fr_x0_r < fr_x1_r) ? fr_x0_r : fr_x1_r;
    xx01   = (fr_x0_r > fr_x1_r) ? fr_x0_r : fr_x1_r;
    my01   = (fr_y0_r < fr_y1_r) ? fr_y0_r : fr_y1_r;
    xy01   = (fr_y0_r > fr_y1_r) ? fr_y0_r : fr_y1_r;
    minx   = (mx01 < fr_x2_r) ? mx01 : fr_x2_r;
    maxx   = (xx01 > fr_x2_r) ? xx01 : fr_x2_r;
    miny   = (my01 < fr_y2_r) ? my01 : fr_y2_r;
    maxy   = (xy01 > fr_y2_r) ? xy01 : fr_y2_r;
    minx_e = (COORD_W+1)'(minx);
    miny_e = (COORD_W+1)'(miny);
    culled = (minx_e >= spanx) || (miny_e >= spany) ||
             maxx[COORD_W-1] || maxy[COORD_W-1];
    // a box straddling the origin of a zero-sized grid gets an id but no tiles
    grid_empty = (tcx == '0) || (tcy == '0);
    mtx    = maxx[COORD_W-1:TILE_SHIFT];
    mty    = maxy[COORD_W-1:TILE_SHIFT];
    miss   = (TCX_W'(fr_tile_x_r) >= tcx) || (TCY_W'(fr_tile_y_r) >= tcy);

    q_data.tx0     = minx[COORD_W-1] ? '0 : minx[TILE_SHIFT +: TX_W];
    q_data.ty0     = miny[COORD_W-1] ? '0 : miny[TILE_SHIFT +: TY_W];
    q_data.tx1     = (mtx > MT_W'(tcx_m1)) ? TX_W'(tcx_m1) : mtx[TX_W-1:0];
    q_data.ty1     = (mty > MT_W'(tcy_m1)) ? TY_W'(tcy_m1) : mty[TY_W-1:0];
    q_data.rd_tile = {fr_tile_y_r, fr_tile_x_r};
    q_data.rd_pos  = fr_pos_r;
    case (fr_action_r)
      ACT_BIN:   q_data.op = culled ? OP_CULL : (grid_empty ? OP_BIN_EMPTY : OP_BIN);
      ACT_READ:  q_data.op = miss ? OP_MISS : OP_READ;
      ACT_CLEAR: q_data.op = OP_CLEAR;
      default:   q_data.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/ttb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_queue
// Short command queue between the classifier and the bin engine.
// ----------------------------------------------------------------------------
module ttb_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  ttb_pkg::cmd_t      push_data,
  output logic               full,
  input  wire logic          pop,
  output ttb_pkg::cmd_t      head,
  output logic               empty
);
  import ttb_pkg::*;

  cmd_t               q_mem [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = q_mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ttb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_back
// Bin engine: owns the bin count and bin entry memories, walks covered
// tiles one per cycle, serves reads and clears, and drives the result register.
// ----------------------------------------------------------------------------
module ttb_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  ttb_pkg::cmd_t                    q_head,
  output logic                             q_pop,
  output logic                             init_busy,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ttb_pkg::TRI_W-1:0]        out_triangle_id,
  output logic [ttb_pkg::COV_W-1:0]        out_tiles_covered,
  output logic                             out_culled,
  output logic                             out_bin_overflow,
  output logic [ttb_pkg::CNT_W-1:0]        out_bin_count,
  output logic [ttb_pkg::TRI_W-1:0]        out_entry_triangle
);
  import ttb_pkg::*;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_BIN  = 6'b000100,
    S_RD   = 6'b001000,
    S_RDW  = 6'b010000,
    S_RES  = 6'b100000
  } state_t;

  logic [CNT_W-1:0]    cnt_mem [NUM_TILES];
  logic [TRI_W-1:0]    st_mem  [2**STORE_AW];

  state_t              state_r, state_nxt;
  logic                init_r, init_nxt;
  logic [TILE_W-1:0]   clr_addr_r, clr_addr_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [TX_W-1:0]     cur_tx_r, cur_tx_nxt;
  logic [TY_W-1:0]     cur_ty_r, cur_ty_nxt;
  logic                issue_done_r, issue_done_nxt;
  logic                p1_valid_r, p1_valid_nxt;
  logic [TILE_W-1:0]   p1_tile_r, p1_tile_nxt;
  logic [TRI_W-1:0]    id_r, id_nxt;
  logic [TRI_W-1:0]    next_tri_r, next_tri_nxt;
  logic [COV_W-1:0]    covered_r, covered_nxt;
  logic                ovf_r, ovf_nxt;
  logic [CNT_W-1:0]    rd_count_r, rd_count_nxt;
  logic [TRI_W-1:0]    rd_entry_r, rd_entry_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_load;

  logic                cnt_we;
  logic [TILE_W-1:0]   cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]    cnt_wdata, cnt_rdata_r;
  logic                st_we;
  logic [STORE_AW-1:0] st_waddr, st_raddr;
  logic [TRI_W-1:0]    st_wdata, st_rdata_r;

  assign init_busy = init_r;
  assign out_valid = out_valid_r;
  assign cnt_raddr = (state_r == S_BIN) ? {cur_ty_r, cur_tx_r} : cmd_r.rd_tile;
  assign st_raddr  = {cmd_r.rd_tile, cmd_r.rd_pos};

  always_comb begin
    state_nxt      = state_r;
    init_nxt       = init_r;
    clr_addr_nxt   = clr_addr_r;
    cmd_nxt        = cmd_r;
    cur_tx_nxt     = cur_tx_r;
    cur_ty_nxt     = cur_ty_r;
    issue_done_nxt = issue_done_r;
    p1_valid_nxt   = 1'b0;
    p1_tile_nxt    = p1_tile_r;
    id_nxt         = id_r;
    next_tri_nxt   = next_tri_r;
    covered_nxt    = covered_r;
    ovf_nxt        = ovf_r;
    rd_count_nxt   = rd_count_r;
    rd_entry_nxt   = rd_entry_r;
    q_pop          = 1'b0;
    out_load       = 1'b0;
    cnt_we         = 1'b0;
    cnt_waddr      = clr_addr_r;
    cnt_wdata      = '0;
    st_we          = 1'b0;
    st_waddr       = {p1_tile_r, cnt_rdata_r[POS_W-1:0]};
    st_wdata       = id_r;

    unique case (state_r)
      S_CLR: begin
        cnt_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + TILE_W'(1);
        if (clr_addr_r == TILE_W'(NUM_TILES - 1)) begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? S_IDLE : S_RES;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          unique case (q_head.op)
            OP_BIN: begin
              id_nxt         = next_tri_r;
              next_tri_nxt   = next_tri_r + TRI_W'(1);
              cur_tx_nxt     = q_head.tx0;
              cur_ty_nxt     = q_head.ty0;
              issue_done_nxt = 1'b0;
              covered_nxt    = '0;
              ovf_nxt        = 1'b0;
              state_nxt      = S_BIN;
            end
            OP_BIN_EMPTY: begin
              id_nxt       = next_tri_r;
              next_tri_nxt = next_tri_r + TRI_W'(1);
              covered_nxt  = '0;
              ovf_nxt      = 1'b0;
              state_nxt    = S_RES;
            end
            OP_READ: state_nxt = S_RD;
            OP_CLEAR: begin
              clr_addr_nxt = '0;
              next_tri_nxt = '0;
              state_nxt    = S_CLR;
            end
            default: state_nxt = S_RES;
          endcase
        end
      end
      S_BIN: begin
        // issue count read for the next tile, append for the previous one
        if (!issue_done_r) begin
          p1_valid_nxt = 1'b1;
          p1_tile_nxt  = {cur_ty_r, cur_tx_r};
          if (cur_tx_r == cmd_r.tx1) begin
            cur_tx_nxt = cmd_r.tx0;
            if (cur_ty_r == cmd_r.ty1) begin
              issue_done_nxt = 1'b1;
            end else begin
              cur_ty_nxt = cur_ty_r + TY_W'(1);
            end
          end else begin
            cur_tx_nxt = cur_tx_r + TX_W'(1);
          end
        end
        if (p1_valid_r) begin
          if (cnt_rdata_r >= CNT_W'(BIN_CAPACITY)) begin
            ovf_nxt = 1'b1;
          end else begin
            cnt_we      = 1'b1;
            cnt_waddr   = p1_tile_r;
            cnt_wdata   = cnt_rdata_r + CNT_W'(1);
            st_we       = 1'b1;
            covered_nxt = covered_r + COV_W'(1);
          end
        end
        if (issue_done_r && !p1_valid_r) begin
          state_nxt = S_RES;
        end
      end
      S_RD: state_nxt = S_RDW;
      S_RDW: begin
        rd_count_nxt = cnt_rdata_r;
        rd_entry_nxt = (CNT_W'(cmd_r.rd_pos) < cnt_rdata_r) ? st_rdata_r : '0;
        state_nxt    = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      init_r       <= 1'b1;
      clr_addr_r   <= '0;
      next_tri_r   <= '0;
      p1_valid_r   <= 1'b0;
      issue_done_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_r       <= init_nxt;
      clr_addr_r   <= clr_addr_nxt;
      next_tri_r   <= next_tri_nxt;
      p1_valid_r   <= p1_valid_nxt;
      issue_done_r <= issue_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cur_tx_r   <= cur_tx_nxt;
    cur_ty_r   <= cur_ty_nxt;
    p1_tile_r  <= p1_tile_nxt;
    id_r       <= id_nxt;
    covered_r  <= covered_nxt;
    ovf_r      <= ovf_nxt;
    rd_count_r <= rd_count_nxt;
    rd_entry_r <= rd_entry_nxt;
    if (out_load) begin
      out_triangle_id    <= '0;
      out_tiles_covered  <= '0;
      out_culled         <= 1'b0;
      out_bin_overflow   <= 1'b0;
      out_bin_count      <= '0;
      out_entry_triangle <= '0;
      unique case (cmd_r.op)
        OP_BIN, OP_BIN_EMPTY: begin
          out_triangle_id   <= id_r;
          out_tiles_covered <= covered_r;
          out_bin_overflow  <= ovf_r;
        end
        OP_CULL: out_culled <= 1'b1;
        OP_READ: begin
          out_bin_count      <= rd_count_r;
          out_entry_triangle <= rd_entry_r;
        end
        default: ;
      endcase
    end
  end

  // bin count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_r <= cnt_mem[cnt_raddr];
  end

  // bin entry memory
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rdata_r <= st_mem[st_raddr];
  end

endmodule
`default_nettype wire
